[rtl/core/histogram_percentile_threshold_top_assert.svh]
// Assertion macros shared by the checker of the percentile threshold block.
`ifndef HISTOGRAM_PERCENTILE_THRESHOLD_TOP_ASSERT_SVH
`define HISTOGRAM_PERCENTILE_THRESHOLD_TOP_ASSERT_SVH

// The consequent must hold on the cycle after the antecedent.
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold on the same cycle as the antecedent.
`define HPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/hpt_pkg.sv]
// Package with the constants and types of the percentile threshold block.
`timescale 1ns / 1ps
package hpt_pkg;

    localparam int NUM_BINS   = 256;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int MAX_PIXELS = 65536;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int Q_W        = 17;
    localparam int Q_FRAC     = 16;
    localparam int TGT_W      = Q_W + CNT_W;
    localparam int THR_W      = 8;

    localparam logic [BIN_W-1:0] TOP_VALUE = BIN_W'(NUM_BINS - 1);
    localparam logic [Q_W-1:0]   Q_ONE     = Q_W'(1 << Q_FRAC);
    localparam logic [Q_W-1:0]   PCT_RESET = Q_W'(9830);
    localparam logic [THR_W-1:0] FB_RESET  = THR_W'(30);

    localparam logic CFG_PERCENTILE = 1'b0;
    localparam logic CFG_FALLBACK   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic             we;
        logic [BIN_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [BIN_W-1:0] raddr;
    } t_ram_req;

endpackage

[rtl/core/hpt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/hpt_accum.sv]
// Histogram update pipeline with forwarding and the region pixel counter.
`timescale 1ns / 1ps
module hpt_accum import hpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [BIN_W-1:0] i_pixel,
    input  logic             i_cnt_clr,
    input  logic [CNT_W-1:0] i_rdata,
    output t_ram_req         o_req,
    output logic [CNT_W-1:0] o_count
);

    logic             r_s1_vld;
    logic [BIN_W-1:0] r_s1_addr;
    logic             r_fw_vld;
    logic [CNT_W-1:0] r_fw_data;
    logic [CNT_W-1:0] r_count;
    logic             counted;
    logic             bin_upd;
    logic [CNT_W-1:0] wdata;

    assign counted = i_take && (r_count < CNT_W'(MAX_PIXELS));
    assign bin_upd = counted && (i_pixel != TOP_VALUE);
    assign wdata   = (r_fw_vld ? r_fw_data : i_rdata) + CNT_W'(1);

    assign o_req.we    = r_s1_vld;
    assign o_req.waddr = r_s1_addr;
    assign o_req.wdata = wdata;
    assign o_req.raddr = i_pixel;
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_s1_vld <= bin_upd;
            r_fw_vld <= bin_upd && r_s1_vld && (i_pixel == r_s1_addr);
            if (i_cnt_clr) begin
                r_count <= '0;
            end else if (counted) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        r_s1_addr <= i_pixel;
        r_fw_data <= wdata;
    end

endmodule

[rtl/core/hpt_ctrl.sv]
// Sequencer for the clearing pass, the percentile scan and the result register.
`timescale 1ns / 1ps
module hpt_ctrl import hpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [Q_W-1:0]   i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_last_pixel,
    input  logic             i_out_stall,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_rdata,
    output logic             o_take,
    output logic             o_cnt_clr,
    output logic             o_own,
    output t_ram_req         o_req,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output logic [THR_W-1:0] o_threshold,
    output logic             o_found
);

    t_state           r_state, n_state;
    logic [Q_W-1:0]   r_pct;
    logic [THR_W-1:0] r_fb;
    logic [BIN_W-1:0] r_addr, n_addr;
    logic [TGT_W-1:0] r_target, n_target;
    logic [CNT_W-1:0] r_sum, n_sum;
    logic             r_found, n_found;
    logic [BIN_W-1:0] r_thr, n_thr;
    logic             r_rd_vld, n_rd_vld;
    logic [BIN_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_out_vld, n_out_vld;
    logic [THR_W-1:0] r_out_thr, n_out_thr;
    logic             r_out_found, n_out_found;
    logic [Q_W-1:0]   q_clamp;
    logic [CNT_W-1:0] sum_add;
    logic             hit;

    assign q_clamp = (r_pct > Q_ONE) ? Q_ONE : r_pct;
    assign sum_add = r_sum + i_rdata;
    assign hit     = TGT_W'({sum_add, Q_FRAC'(0)}) >= r_target;

    assign o_take      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_own       = (r_state != ST_IDLE) && (r_state != ST_DRAIN);
    assign o_req.we    = (r_state == ST_CLEAR) || (r_state == ST_SCAN);
    assign o_req.waddr = r_addr;
    assign o_req.wdata = '0;
    assign o_req.raddr = r_addr;

    assign o_out_valid = r_out_vld;
    assign o_threshold = r_out_thr;
    assign o_found     = r_out_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_target    = r_target;
        n_sum       = r_sum;
        n_found     = r_found;
        n_thr       = r_thr;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_out_vld   = r_out_vld;
        n_out_thr   = r_out_thr;
        n_out_found = r_out_found;
        o_cnt_clr   = 1'b0;

        if (r_rd_vld) begin
            n_sum = sum_add;
            if (!r_found && hit) begin
                n_found = 1'b1;
                n_thr   = r_rd_idx;
            end
        end
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr - BIN_W'(1);
                if (r_addr == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_take && i_last_pixel) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_target = TGT_W'(q_clamp) * TGT_W'(i_count);
                n_sum    = '0;
                n_found  = 1'b0;
                n_addr   = TOP_VALUE;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_addr;
                n_addr   = r_addr - BIN_W'(1);
                if (r_addr == '0) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_thr   = n_found ? THR_W'(n_thr) : r_fb;
                    n_out_found = n_found;
                    o_cnt_clr   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct     <= PCT_RESET;
            r_fb      <= FB_RESET;
            r_addr    <= TOP_VALUE;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERCENTILE: r_pct <= i_cfg_wdata;
                    CFG_FALLBACK:   r_fb  <= i_cfg_wdata[THR_W-1:0];
                    default:        r_pct <= r_pct;
                endcase
            end
            r_addr    <= n_addr;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
        r_target    <= n_target;
        r_sum       <= n_sum;
        r_thr       <= n_thr;
        r_rd_idx    <= n_rd_idx;
        r_out_thr   <= n_out_thr;
        r_out_found <= n_out_found;
    end

endmodule

[rtl/core/histogram_percentile_threshold_top.sv]
// Top level of the histogram percentile threshold block.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_pixel, i_last_pixel
// out       output     o_out_valid / i_out_stall o_threshold, o_found
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// Pixels are taken at one beat per cycle while o_in_stall is low; the bin
// update is a two-stage read-modify-write on the bin memory with forwarding
// between beats. After the beat marked last, input stalls through a drain
// state, a scan of the bin memory (one bin per cycle), and a result state.
// The scan writes each bin back to zero, so the next region starts clean.
// After reset a clearing pass over all bins runs with the input stalled.
// A result still stalled from the last region holds the block in its result state until taken.
`timescale 1ns / 1ps
module histogram_percentile_threshold_top import hpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [Q_W-1:0]   i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [THR_W-1:0] i_pixel,
    input  logic             i_last_pixel,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [THR_W-1:0] o_threshold,
    output logic             o_found
);

    t_ram_req         acc_req;
    t_ram_req         ctrl_req;
    t_ram_req         ram_req;
    logic             ctrl_own;
    logic             take;
    logic             cnt_clr;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] rdata;

    assign ram_req = ctrl_own ? ctrl_req : acc_req;

    hpt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    hpt_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_pixel   (BIN_W'(i_pixel)),
        .i_cnt_clr (cnt_clr),
        .i_rdata   (rdata),
        .o_req     (acc_req),
        .o_count   (count)
    );

    hpt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_last_pixel (i_last_pixel),
        .i_out_stall  (i_out_stall),
        .i_count      (count),
        .i_rdata      (rdata),
        .o_take       (take),
        .o_cnt_clr    (cnt_clr),
        .o_own        (ctrl_own),
        .o_req        (ctrl_req),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_threshold  (o_threshold),
        .o_found      (o_found)
    );

endmodule

[rtl/core/hpt_checker.sv]
// Port-level checker for the percentile threshold block, with its bind.
`timescale 1ns / 1ps
`include "histogram_percentile_threshold_top_assert.svh"
module hpt_checker import hpt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic             i_cfg_idx,
    input logic [Q_W-1:0]   i_cfg_wdata,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic [THR_W-1:0] i_pixel,
    input logic             i_last_pixel,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [THR_W-1:0] o_threshold,
    input logic             o_found
);

    `HPT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result beat dropped")
    `HPT_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_threshold) && $stable(o_found), "stalled result changed")
    `HPT_ASSERT_NEXT(a_last_busy, i_in_valid && !o_in_stall && i_last_pixel, o_in_stall, "input not stalled after last beat")
    `HPT_ASSERT_NOW(a_res_in_scan, $rose(o_out_valid), $past(o_in_stall), "result without a scan")

endmodule

bind histogram_percentile_threshold_top hpt_checker u_hpt_checker (.*);
